/* hw/rtl/lrast_pkg.sv */
// Shared types and constants for the lazy range-add / range-sum tree.
package lrast_pkg;

   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 10;
   localparam int DATA_W  = 64;
   localparam int COUNT_W = 11;

   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   // operation handed from the front end to the tree walker
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] lo;
      logic [INDEX_W-1:0] hi;
      logic [DATA_W-1:0]  value;
   } op_type;

endpackage

/* hw/rtl/lrast_elem_store.sv */
// Element store: one word per element, cleared by a sweep after reset or a count write.
module lrast_elem_store import lrast_pkg::*; #(
   parameter int SIZE = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear_start,
   output logic                    busy,
   input  logic                    wr_en,
   input  logic [$clog2(SIZE)-1:0] wr_addr,
   input  logic [DATA_W-1:0]       wr_data,
   input  logic [$clog2(SIZE)-1:0] rd_addr,
   output logic [DATA_W-1:0]       rd_data
);
   localparam int AW = $clog2(SIZE);

   logic [DATA_W-1:0] mem [SIZE];
   logic [AW-1:0]     clr_ff, clr_in;
   logic              busy_ff, busy_in;

   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (clear_start) begin
         clr_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == AW'(SIZE - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) mem[clr_ff] <= '0;
      else if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

   assign busy = busy_ff;
endmodule

/* hw/rtl/lazy_range_add_sum_tree.sv */
// Top level of the lazy range-add / range-sum tree over signed 64-bit elements.
// One operation is taken at a time. A load writes the one element at lo and a range add
// walks the chosen elements, each through a single shared 64-bit adder on the element
// store, reading then writing each element. A query reads one element per cycle, set by
// the one read port of the store, and holds its result word until rsp_ready takes it.
// After reset and after every element_count write the store is cleared, one element per
// cycle, while no operation is accepted. Results match the lazy tree exactly, since its
// sums are the wrapping sums of the elements.
module lazy_range_add_sum_tree import lrast_pkg::*; #(
   parameter int SIZE = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic [INDEX_W-1:0]        req_lo,
   input  logic [INDEX_W-1:0]        req_hi,
   input  logic signed [DATA_W-1:0]  req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DATA_W-1:0]  rsp_sum,
   input  logic                      csr_write,
   input  logic [COUNT_W-1:0]        csr_data
);
   localparam int AW = $clog2(SIZE);
   localparam int CW = AW + 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RD   = 4'b0010,
      S_EXEC = 4'b0100,
      S_RSP  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in, last_ff, last_in;
   logic [DATA_W-1:0] acc_ff, acc_in, sum_ff, sum_in;
   logic [CW-1:0]     n_eff, hi_c, lo_x;
   logic              busy, wr_en;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data, adder;

   always_comb begin
      if (count_ff == '0) n_eff = CW'(1);
      else if (32'(count_ff) > SIZE) n_eff = CW'(SIZE);
      else n_eff = CW'(count_ff);
      hi_c = (CW'(req_hi) > n_eff - 1'b1) ? n_eff - 1'b1 : CW'(req_hi);
      lo_x = CW'(req_lo);
   end

   lrast_elem_store #(.SIZE(SIZE)) u_store (
      .clock(clock), .reset(reset), .clear_start(csr_write), .busy(busy),
      .wr_en(wr_en), .wr_addr(idx_ff[AW-1:0]), .wr_data(adder),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // the one shared adder: element update or query accumulate
   always_comb begin
      if (op_ff.func == FUNC_LOAD) adder = op_ff.value;
      else if (op_ff.func == FUNC_ADD) adder = rd_data + op_ff.value;
      else adder = acc_ff + rd_data;
   end

   assign req_ready = (state_ff == S_IDLE) && !busy && !csr_write;
   assign wr_en     = (state_ff == S_EXEC) && (op_ff.func != FUNC_QUERY);
   // read is issued for the next idx, so in S_EXEC rd_data holds mem[idx_ff]
   assign rd_addr   = idx_in[AW-1:0];

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      count_in = csr_write ? csr_data : count_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      acc_in   = acc_ff;
      sum_in   = sum_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in  = '{req_func, req_lo, req_hi, req_value};
               idx_in = lo_x;
               acc_in = '0;
               case (req_func)
                  FUNC_LOAD: begin
                     last_in  = lo_x;
                     state_in = (lo_x < n_eff) ? S_RD : S_IDLE;
                  end
                  FUNC_ADD: begin
                     last_in  = hi_c;
                     state_in = (lo_x <= hi_c) ? S_RD : S_IDLE;
                  end
                  FUNC_QUERY: begin
                     last_in = hi_c;
                     if (lo_x <= hi_c) state_in = S_EXEC;
                     else begin
                        sum_in   = '0;
                        state_in = S_RSP;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RD: state_in = S_EXEC;       // read of idx in flight
         S_EXEC: begin
            if (op_ff.func == FUNC_QUERY) begin
               acc_in = adder;
               if (idx_ff == last_ff) begin
                  sum_in   = adder;
                  state_in = S_RSP;
               end else idx_in = idx_ff + 1'b1;
            end else if (idx_ff == last_ff) state_in = S_IDLE;
            else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_RSP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= COUNT_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
      acc_ff  <= acc_in;
      sum_ff  <= sum_in;
   end

   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_sum   = sum_ff;

   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr_en) else $error("element write during clear sweep");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum))
      else $error("result dropped while stalled");
   a_exec_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |-> idx_ff <= last_ff) else $error("walk passed range end");
endmodule
